FILE: hw/rtl/ppp_dfr_pkg.sv
// Package for the PPP-style deframer: byte codes, FCS-16 constants,
// the result record and the per-byte FCS-16 update function.
// No dependencies.
package ppp_dfr_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_MASK  = 8'h20;
  localparam logic [15:0] FCS_POLY  = 16'h8408;
  localparam logic [15:0] FCS_INIT  = 16'hFFFF;
  localparam logic [15:0] FCS_GOOD  = 16'h0F47;
  localparam logic [7:0]  LEN_MAX   = 8'hFF;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] payload_byte;
    logic       frame_good;
    logic [7:0] payload_length;
  } result_t;

  // One byte of the reflected CRC-16, least significant bit first.
  function automatic logic [15:0] fcs_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ FCS_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/ppp_dfr_core.sv
// Frame state of the deframer: escape handling, FCS, byte count, overflow
// and the two-byte holdback. Depends on ppp_dfr_pkg.
module ppp_dfr_core #(
  parameter int MAX_FRAME = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           line_byte,
  output logic                 res_valid,
  output ppp_dfr_pkg::result_t res
);

  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam int XW = (CW > 8) ? CW : 8;

  logic          escape_pending;
  logic [15:0]   crc_register;
  logic [CW-1:0] stored_count;
  logic          overflowed;
  logic [7:0]    held_bytes [2];

  logic          is_flag;
  logic          is_full;
  logic          do_store;
  logic [7:0]    store_data;
  logic [XW-1:0] count_x;
  logic [XW-1:0] len_x;
  logic [7:0]    len;

  assign is_flag    = (line_byte == ppp_dfr_pkg::FLAG_BYTE);
  assign is_full    = (stored_count >= CW'(MAX_FRAME));
  assign do_store   = !is_flag && !is_full &&
                      (escape_pending || (line_byte != ppp_dfr_pkg::ESC_BYTE));
  assign store_data = escape_pending ? (line_byte ^ ppp_dfr_pkg::ESC_MASK) : line_byte;

  assign count_x = XW'(stored_count);
  assign len_x   = (count_x >= XW'(2)) ? (count_x - XW'(2)) : '0;
  assign len     = (len_x > XW'(ppp_dfr_pkg::LEN_MAX)) ? ppp_dfr_pkg::LEN_MAX : len_x[7:0];

  always_comb begin
    res = '0;
    res_valid = 1'b0;
    if (is_flag) begin
      res_valid = 1'b1;
      res.result_kind = 1'b1;
      res.payload_length = len;
      res.frame_good = (count_x > XW'(2)) && !overflowed &&
                       ((crc_register ^ 16'hFFFF) == ppp_dfr_pkg::FCS_GOOD);
    end else if (do_store && (count_x >= XW'(2))) begin
      res_valid = 1'b1;
      res.payload_byte = held_bytes[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      crc_register   <= ppp_dfr_pkg::FCS_INIT;
      stored_count   <= '0;
      overflowed     <= 1'b0;
    end else if (step) begin
      if (is_flag) begin
        crc_register <= ppp_dfr_pkg::FCS_INIT;
        stored_count <= '0;
        overflowed   <= 1'b0;
      end else if (is_full) begin
        overflowed <= 1'b1;
      end else if (escape_pending) begin
        escape_pending <= 1'b0;
      end else if (line_byte == ppp_dfr_pkg::ESC_BYTE) begin
        escape_pending <= 1'b1;
      end
      if (do_store) begin
        crc_register <= ppp_dfr_pkg::fcs_step(crc_register, store_data);
        stored_count <= stored_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && do_store) begin
      held_bytes[0] <= held_bytes[1];
      held_bytes[1] <= store_data;
    end
  end

endmodule

FILE: hw/rtl/ppp_style_deframer_fcs16.sv
// Top level of the PPP-style receive deframer with FCS-16 check.
// Depends on ppp_dfr_pkg and ppp_dfr_core.
//
// Raw line bytes enter on the slave stream, one item per cycle while the
// master side keeps up. Each item passes an input register, then the frame
// logic, whose result lands in an output register; the FCS byte update is
// combinational, which lets the block sustain one item per cycle. Payload
// bytes come out two stored bytes late, so the FCS bytes are never passed on.
// A flag byte yields an end item with tlast high, a good mark and the payload
// length; bytes already sent from a bad frame must be discarded by the user.
module ppp_style_deframer_fcs16 #(
  parameter int MAX_FRAME = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] line_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [8] frame_good,
                                      // [16:9] payload_length, [23:17] zero
  output logic        m_axis_tlast    // result_kind
);

  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 advance;
  logic                 res_valid;
  ppp_dfr_pkg::result_t res;
  ppp_dfr_pkg::result_t out_res;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  ppp_dfr_core #(
    .MAX_FRAME(MAX_FRAME)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .line_byte (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tlast = out_res.result_kind;
  assign m_axis_tdata = {7'b0, out_res.payload_length, out_res.frame_good,
                         out_res.payload_byte};

endmodule
